### hdl/c2s_pkg.sv
package c2s_pkg;

   // Default build: 32-bit coordinates, 32-bit angles, 32 CORDIC steps.
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int ANGLE_WIDTH_DEF  = 32;
   localparam int CORDIC_STEPS_DEF = 32;

   // Bits of the in-plane norm rho, which is scaled so that it always sits below 2^62.
   localparam int RHO_BITS = 62;

   // Angles are unsigned Q0.64 turns inside the datapath.
   localparam logic [63:0] TURN_HALF    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TURN_QUARTER = 64'h4000_0000_0000_0000;
   localparam logic [63:0] TURN_EIGHTH  = 64'h2000_0000_0000_0000;
   localparam logic [63:0] INV_TWO_PI   = 64'h28BE_60DB_9391_054A;

   // CORDIC angle of step idx in Q0.64 turns. Entry 0 is one eighth turn.
   // For later entries, sum the arctangent series in Q0.64 radians using
   // long division by the odd term index, then scale by 1/(2pi).
   // This runs only at elaboration.
   function automatic logic [63:0] c2s_atan(input int idx);
      logic [63:0]  rad;
      logic [63:0]  term;
      logic [63:0]  num;
      logic [64:0]  rem;
      logic [127:0] prod;
      int           sh;
      int           dv;
      rad = '0;
      if (idx == 0) begin
         return TURN_EIGHTH;
      end
      for (int k = 0; k < 32; k++) begin
         sh = idx * (2 * k + 1);
         if (sh <= 63) begin
            dv   = 2 * k + 1;
            num  = 64'd1 << (64 - sh);
            rem  = '0;
            term = '0;
            for (int b = 63; b >= 0; b--) begin
               rem = {rem[63:0], num[b]};
               if (rem >= 65'(dv)) begin
                  rem     = rem - 65'(dv);
                  term[b] = 1'b1;
               end
            end
            if (k[0]) begin
               rad = rad - term;
            end else begin
               rad = rad + term;
            end
         end
      end
      prod = {64'd0, rad} * {64'd0, INV_TWO_PI};
      return prod[127:64];
   endfunction

   // Settle the first-quadrant angle. Handle the cases on an axis, then
   // pull a drifted CORDIC result back into [0, 1/4 turn].
   function automatic logic [63:0] c2s_clamp(input logic [63:0] acc,
                                             input logic zero_b,
                                             input logic zero_a);
      if (zero_b) begin
         return '0;
      end
      if (zero_a) begin
         return TURN_QUARTER;
      end
      if (acc > TURN_HALF) begin
         return '0;
      end
      if (acc > TURN_QUARTER) begin
         return TURN_QUARTER;
      end
      return acc;
   endfunction

endpackage

### hdl/cartesian_to_spherical.sv
// Cartesian to spherical converter. Give it one signed vector (x, y, z) per
// cycle: a transfer happens at each clock edge with start high. busy stays
// low, because the pipeline never stalls. Each result appears on rsp_*
// with rsp_valid high for exactly one cycle, and it must be captured then,
// because the block cannot hold it. Results leave in the order the vectors came in.
// The pipeline has three parts:
//   - the magnitude, square and sum stages;
//   - a 62-stage bit-per-cycle square root, which also resolves the radius in its first
//     COORD_WIDTH stages;
//   - one register stage per CORDIC step, then a stage that folds angles into quadrants
//     and an output rounding stage.
// The radius is floor(sqrt(x^2+y^2+z^2)), exact. The polar angle runs from
// +z and lies in [0, 1/2 turn]. The azimuth runs from +x and lies in [0, 1 turn).
// Both angles are unsigned fractions of a turn times 2^ANGLE_WIDTH.
// A zero vector gives all zeros. A vector on the z axis gives azimuth zero.
module cartesian_to_spherical #(
   parameter int COORD_WIDTH  = c2s_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = c2s_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = c2s_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  logic signed [COORD_WIDTH-1:0] req_z_coord,
   output logic                          rsp_valid,
   output logic        [COORD_WIDTH-1:0] rsp_radius,
   output logic        [ANGLE_WIDTH-1:0] rsp_polar_angle,
   output logic        [ANGLE_WIDTH-1:0] rsp_azimuth
);
   import c2s_pkg::*;

   // Coordinates enter CORDIC scaled by 2^FRAC.
   localparam int FRAC   = 61 - COORD_WIDTH;
   localparam int LO_W   = (COORD_WIDTH + 1) / 2;
   localparam int HI_W   = COORD_WIDTH - LO_W;
   localparam int SQ_W   = 2 * COORD_WIDTH;
   localparam int RHO_SW = 2 * RHO_BITS;
   localparam int NSQ    = RHO_BITS;

   localparam logic [63:0] ROUND_HALF = 64'd1 << (63 - ANGLE_WIDTH);

   // The block never stalls.
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Stage 1: take magnitudes and signs. The most negative pattern
   // maps to its true magnitude 2^(COORD_WIDTH-1).
   // ---------------------------------------------------------------
   logic                   in_vld_ff;
   logic [COORD_WIDTH-1:0] in_mx_ff, in_my_ff, in_mz_ff;
   logic [2:0]             in_sgn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      in_mx_ff  <= req_x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-req_x_coord) : req_x_coord;
      in_my_ff  <= req_y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-req_y_coord) : req_y_coord;
      in_mz_ff  <= req_z_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-req_z_coord) : req_z_coord;
      in_sgn_ff <= {req_z_coord[COORD_WIDTH-1], req_y_coord[COORD_WIDTH-1],
                    req_x_coord[COORD_WIDTH-1]};
   end

   // ---------------------------------------------------------------
   // Stage 2: split each magnitude into halves to form its partial
   // products.
   // ---------------------------------------------------------------
   logic                   pp_vld_ff;
   logic [COORD_WIDTH-1:0] pp_mag_ff [3];
   logic [2*HI_W-1:0]      pp_hh_ff  [3];
   logic [COORD_WIDTH-1:0] pp_hl_ff  [3];
   logic [2*LO_W-1:0]      pp_ll_ff  [3];
   logic [2:0]             pp_sgn_ff;
   logic [COORD_WIDTH-1:0] mag_in    [3];

   assign mag_in[0] = in_mx_ff;
   assign mag_in[1] = in_my_ff;
   assign mag_in[2] = in_mz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff <= 1'b0;
      end else begin
         pp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         pp_mag_ff[c] <= mag_in[c];
         pp_hh_ff[c]  <= (2*HI_W)'(mag_in[c][COORD_WIDTH-1:LO_W])
                         * (2*HI_W)'(mag_in[c][COORD_WIDTH-1:LO_W]);
         pp_hl_ff[c]  <= COORD_WIDTH'(mag_in[c][COORD_WIDTH-1:LO_W])
                         * COORD_WIDTH'(mag_in[c][LO_W-1:0]);
         pp_ll_ff[c]  <= (2*LO_W)'(mag_in[c][LO_W-1:0]) * (2*LO_W)'(mag_in[c][LO_W-1:0]);
      end
      pp_sgn_ff <= in_sgn_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: assemble the squares.
   // ---------------------------------------------------------------
   logic                   sqr_vld_ff;
   logic [SQ_W-1:0]        sqr_ff    [3];
   logic [COORD_WIDTH-1:0] sqr_mag_ff [3];
   logic [2:0]             sqr_sgn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqr_vld_ff <= 1'b0;
      end else begin
         sqr_vld_ff <= pp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         sqr_ff[c] <= (SQ_W'(pp_hh_ff[c]) << (2 * LO_W))
                    + (SQ_W'(pp_hl_ff[c]) << (LO_W + 1))
                    + SQ_W'(pp_ll_ff[c]);
      end
      sqr_mag_ff <= pp_mag_ff;
      sqr_sgn_ff <= pp_sgn_ff;
   end

   // ---------------------------------------------------------------
   // Stage 4 (square-root slot 0): form x^2+y^2 and x^2+y^2+z^2 and
   // load both root pipelines.
   // ---------------------------------------------------------------
   logic                   sq_vld_ff      [NSQ+1];
   logic [RHO_SW-1:0]      sq_rho_rem_ff  [NSQ+1];
   logic [RHO_BITS-1:0]    sq_rho_root_ff [NSQ+1];
   logic [SQ_W-1:0]        sq_rad_rem_ff  [NSQ+1];
   logic [COORD_WIDTH-1:0] sq_rad_root_ff [NSQ+1];
   logic [COORD_WIDTH-1:0] sq_mag_ff      [NSQ+1][3];
   logic [2:0]             sq_sgn_ff      [NSQ+1];
   logic [SQ_W-1:0]        sxy_in;

   assign sxy_in = sqr_ff[0] + sqr_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= sqr_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_rho_rem_ff[0]  <= RHO_SW'(sxy_in) << (2 * FRAC);
      sq_rho_root_ff[0] <= '0;
      sq_rad_rem_ff[0]  <= sxy_in + sqr_ff[2];
      sq_rad_root_ff[0] <= '0;
      sq_mag_ff[0]      <= sqr_mag_ff;
      sq_sgn_ff[0]      <= sqr_sgn_ff;
   end

   // Restoring square root, one result bit per stage. Keep rem = s - root^2;
   // setting bit b costs (root << (b+1)) + 4^b.
   for (genvar j = 1; j <= NSQ; j++) begin : g_sqrt
      localparam int RB = RHO_BITS - j;
      logic [RHO_SW-1:0] rho_trial_in;

      assign rho_trial_in = (RHO_SW'(sq_rho_root_ff[j-1]) << (RB + 1))
                          + (RHO_SW'(1) << (2 * RB));

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j] <= 1'b0;
         end else begin
            sq_vld_ff[j] <= sq_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (sq_rho_rem_ff[j-1] >= rho_trial_in) begin
            sq_rho_rem_ff[j]  <= sq_rho_rem_ff[j-1] - rho_trial_in;
            sq_rho_root_ff[j] <= sq_rho_root_ff[j-1] | (RHO_BITS'(1) << RB);
         end else begin
            sq_rho_rem_ff[j]  <= sq_rho_rem_ff[j-1];
            sq_rho_root_ff[j] <= sq_rho_root_ff[j-1];
         end
         sq_mag_ff[j] <= sq_mag_ff[j-1];
         sq_sgn_ff[j] <= sq_sgn_ff[j-1];
      end

      if (j <= COORD_WIDTH) begin : g_rad
         localparam int DB = COORD_WIDTH - j;
         logic [SQ_W-1:0] rad_trial_in;

         assign rad_trial_in = (SQ_W'(sq_rad_root_ff[j-1]) << (DB + 1))
                             + (SQ_W'(1) << (2 * DB));

         always_ff @(posedge clock) begin
            if (sq_rad_rem_ff[j-1] >= rad_trial_in) begin
               sq_rad_rem_ff[j]  <= sq_rad_rem_ff[j-1] - rad_trial_in;
               sq_rad_root_ff[j] <= sq_rad_root_ff[j-1] | (COORD_WIDTH'(1) << DB);
            end else begin
               sq_rad_rem_ff[j]  <= sq_rad_rem_ff[j-1];
               sq_rad_root_ff[j] <= sq_rad_root_ff[j-1];
            end
         end
      end else begin : g_rad_hold
         // Radius is resolved; carry it along.
         always_ff @(posedge clock) begin
            sq_rad_rem_ff[j]  <= sq_rad_rem_ff[j-1];
            sq_rad_root_ff[j] <= sq_rad_root_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // CORDIC vectoring: slot 0 loads both engines, then one register
   // stage per step. Azimuth works on (|x|, |y|), polar on (|z|, rho).
   // ---------------------------------------------------------------
   logic                   cd_vld_ff    [CORDIC_STEPS+1];
   logic signed [63:0]     cd_az_a_ff   [CORDIC_STEPS+1];
   logic signed [63:0]     cd_az_b_ff   [CORDIC_STEPS+1];
   logic [63:0]            cd_az_acc_ff [CORDIC_STEPS+1];
   logic signed [63:0]     cd_pl_a_ff   [CORDIC_STEPS+1];
   logic signed [63:0]     cd_pl_b_ff   [CORDIC_STEPS+1];
   logic [63:0]            cd_pl_acc_ff [CORDIC_STEPS+1];
   logic [3:0]             cd_axis_ff   [CORDIC_STEPS+1];
   logic [2:0]             cd_sgn_ff    [CORDIC_STEPS+1];
   logic [COORD_WIDTH-1:0] cd_rad_ff    [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_vld_ff[0] <= 1'b0;
      end else begin
         cd_vld_ff[0] <= sq_vld_ff[NSQ];
      end
   end

   always_ff @(posedge clock) begin
      cd_az_a_ff[0]   <= $signed(64'(sq_mag_ff[NSQ][0]) << FRAC);
      cd_az_b_ff[0]   <= $signed(64'(sq_mag_ff[NSQ][1]) << FRAC);
      cd_az_acc_ff[0] <= '0;
      cd_pl_a_ff[0]   <= $signed(64'(sq_mag_ff[NSQ][2]) << FRAC);
      cd_pl_b_ff[0]   <= $signed(64'(sq_rho_root_ff[NSQ]));
      cd_pl_acc_ff[0] <= '0;
      // Axis flags: {polar a zero, polar b zero, azimuth a zero, azimuth b zero}.
      cd_axis_ff[0]   <= {sq_mag_ff[NSQ][2] == '0, sq_rho_root_ff[NSQ] == '0,
                          sq_mag_ff[NSQ][0] == '0, sq_mag_ff[NSQ][1] == '0};
      cd_sgn_ff[0]    <= sq_sgn_ff[NSQ];
      cd_rad_ff[0]    <= sq_rad_root_ff[NSQ];
   end

   for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_cordic
      localparam int          SH  = i - 1;
      localparam logic [63:0] ANG = c2s_atan(i - 1);
      logic signed [63:0] az_a_in, az_b_in, pl_a_in, pl_b_in;
      logic [63:0]        az_acc_in, pl_acc_in;

      // Rotate toward the x axis; both updates use the old pair.
      always_comb begin
         if (!cd_az_b_ff[i-1][63]) begin
            az_a_in   = cd_az_a_ff[i-1] + (cd_az_b_ff[i-1] >>> SH);
            az_b_in   = cd_az_b_ff[i-1] - (cd_az_a_ff[i-1] >>> SH);
            az_acc_in = cd_az_acc_ff[i-1] + ANG;
         end else begin
            az_a_in   = cd_az_a_ff[i-1] - (cd_az_b_ff[i-1] >>> SH);
            az_b_in   = cd_az_b_ff[i-1] + (cd_az_a_ff[i-1] >>> SH);
            az_acc_in = cd_az_acc_ff[i-1] - ANG;
         end
         if (!cd_pl_b_ff[i-1][63]) begin
            pl_a_in   = cd_pl_a_ff[i-1] + (cd_pl_b_ff[i-1] >>> SH);
            pl_b_in   = cd_pl_b_ff[i-1] - (cd_pl_a_ff[i-1] >>> SH);
            pl_acc_in = cd_pl_acc_ff[i-1] + ANG;
         end else begin
            pl_a_in   = cd_pl_a_ff[i-1] - (cd_pl_b_ff[i-1] >>> SH);
            pl_b_in   = cd_pl_b_ff[i-1] + (cd_pl_a_ff[i-1] >>> SH);
            pl_acc_in = cd_pl_acc_ff[i-1] - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_vld_ff[i] <= 1'b0;
         end else begin
            cd_vld_ff[i] <= cd_vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         cd_az_a_ff[i]   <= az_a_in;
         cd_az_b_ff[i]   <= az_b_in;
         cd_az_acc_ff[i] <= az_acc_in;
         cd_pl_a_ff[i]   <= pl_a_in;
         cd_pl_b_ff[i]   <= pl_b_in;
         cd_pl_acc_ff[i] <= pl_acc_in;
         cd_axis_ff[i]   <= cd_axis_ff[i-1];
         cd_sgn_ff[i]    <= cd_sgn_ff[i-1];
         cd_rad_ff[i]    <= cd_rad_ff[i-1];
      end
   end

   // ---------------------------------------------------------------
   // Quadrant stage: clamp, then unfold. A negative x mirrors about
   // 1/4 turn, a negative y negates mod one turn, and a negative z
   // mirrors the polar angle.
   // ---------------------------------------------------------------
   logic                   q_vld_ff;
   logic [63:0]            q_az_ff, q_pl_ff;
   logic [63:0]            q_az_in, q_pl_in;
   logic [COORD_WIDTH-1:0] q_rad_ff;

   always_comb begin
      q_az_in = c2s_clamp(cd_az_acc_ff[CORDIC_STEPS], cd_axis_ff[CORDIC_STEPS][0],
                          cd_axis_ff[CORDIC_STEPS][1]);
      if (cd_sgn_ff[CORDIC_STEPS][0]) begin
         q_az_in = TURN_HALF - q_az_in;
      end
      if (cd_sgn_ff[CORDIC_STEPS][1]) begin
         q_az_in = 64'd0 - q_az_in;
      end
      q_pl_in = c2s_clamp(cd_pl_acc_ff[CORDIC_STEPS], cd_axis_ff[CORDIC_STEPS][2],
                          cd_axis_ff[CORDIC_STEPS][3]);
      if (cd_sgn_ff[CORDIC_STEPS][2]) begin
         q_pl_in = TURN_HALF - q_pl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= cd_vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      q_az_ff  <= q_az_in;
      q_pl_ff  <= q_pl_in;
      q_rad_ff <= cd_rad_ff[CORDIC_STEPS];
   end

   // ---------------------------------------------------------------
   // Output stage: round to nearest at ANGLE_WIDTH bits. An azimuth
   // that rounds up to a full turn wraps to zero.
   // ---------------------------------------------------------------
   logic [63:0]            az_rnd_in, pl_rnd_in;
   logic                   out_vld_ff;
   logic [COORD_WIDTH-1:0] out_rad_ff;
   logic [ANGLE_WIDTH-1:0] out_pl_ff, out_az_ff;

   assign az_rnd_in = q_az_ff + ROUND_HALF;
   assign pl_rnd_in = q_pl_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= q_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_rad_ff <= q_rad_ff;
      out_pl_ff  <= pl_rnd_in[63 -: ANGLE_WIDTH];
      out_az_ff  <= az_rnd_in[63 -: ANGLE_WIDTH];
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_radius      = out_rad_ff;
   assign rsp_polar_angle = out_pl_ff;
   assign rsp_azimuth     = out_az_ff;

`ifndef SYNTHESIS
   // A zero radius only comes from the zero vector, which has zero angles.
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_radius == '0) |-> (rsp_polar_angle == '0 && rsp_azimuth == '0))
      else $error("zero radius with nonzero angle");

   // The polar angle never exceeds half a turn.
   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_polar_angle <= (ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1))))
      else $error("polar angle beyond half turn");

   // A result strobe follows a valid quadrant stage in the next cycle.
   a_strobe_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(q_vld_ff))
      else $error("result strobe without a result in flight");
`endif

endmodule
